### rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types and constants for the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // result status codes
  typedef enum logic [1:0] {
    ST_DATA   = 2'd0,
    ST_DONE   = 2'd1,
    ST_BADESC = 2'd2,
    ST_UNTERM = 2'd3
  } jsu_status_t;

  // decoder mode
  typedef enum logic [1:0] {
    MODE_PLAIN   = 2'd0,
    MODE_ESCAPE  = 2'd1,
    MODE_UNICODE = 2'd2
  } jsu_mode_t;

  // one queued command: up to three result bytes, first in bytes[0]
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      last_idx;
    jsu_status_t     status;
  } jsu_entry_t;

  // queue flags seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } jsu_q_flags_t;

  // character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;

  // escaped values
  localparam logic [7:0] VAL_BS = 8'h08;
  localparam logic [7:0] VAL_FF = 8'h0C;
  localparam logic [7:0] VAL_LF = 8'h0A;
  localparam logic [7:0] VAL_CR = 8'h0D;
  localparam logic [7:0] VAL_HT = 8'h09;

  // hex letter offsets
  localparam logic [7:0] HEX_UPPER_OFS = 8'd55;
  localparam logic [7:0] HEX_LOWER_OFS = 8'd87;

  // utf-8 limits and marks
  localparam logic [15:0] UTF8_MAX1 = 16'h007F;
  localparam logic [15:0] UTF8_MAX2 = 16'h07FF;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;

  // last_idx codes
  localparam logic [1:0] IDX_ONE   = 2'd0;
  localparam logic [1:0] IDX_TWO   = 2'd1;
  localparam logic [1:0] IDX_THREE = 2'd2;

endpackage

### rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// accepts raw string bytes, tracks escapes and builds result commands
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_stall,
  input  logic [7:0]   char_byte,
  input  logic         end_of_input,
  input  jsu_q_flags_t q_flags,
  output logic         push,
  output jsu_entry_t   push_entry
);

  jsu_mode_t   mode, mode_next;
  logic [1:0]  hex_cnt, hex_cnt_next;
  logic [15:0] code, code_next;

  logic        accept;
  logic        end_hit;
  logic        hex_ok;
  logic [3:0]  nib;
  logic [7:0]  diff_upper, diff_lower;
  logic [15:0] cp;
  logic        emit;

  assign byte_stall = q_flags.full;
  assign accept     = byte_valid & ~q_flags.full;
  assign end_hit    = end_of_input | (char_byte == 8'd0);

  assign diff_upper = char_byte - HEX_UPPER_OFS;
  assign diff_lower = char_byte - HEX_LOWER_OFS;

  // hex digit decode
  always_comb begin
    hex_ok = 1'b1;
    nib    = 4'd0;
    if (char_byte >= CH_0 && char_byte <= CH_9) begin
      nib = char_byte[3:0];
    end else if (char_byte >= CH_UA && char_byte <= CH_UF) begin
      nib = diff_upper[3:0];
    end else if (char_byte >= CH_LA && char_byte <= CH_LF) begin
      nib = diff_lower[3:0];
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp = {code[11:0], nib};

  // next mode
  always_comb begin
    mode_next = MODE_PLAIN;
    if (!end_hit) begin
      unique case (mode)
        MODE_PLAIN:   mode_next = (char_byte == CH_BSLASH) ? MODE_ESCAPE : MODE_PLAIN;
        MODE_ESCAPE:  mode_next = (char_byte == CH_U) ? MODE_UNICODE : MODE_PLAIN;
        MODE_UNICODE: mode_next = (hex_ok && hex_cnt != 2'd3) ? MODE_UNICODE : MODE_PLAIN;
        default:      mode_next = MODE_PLAIN;
      endcase
    end
  end

  // command and digit accumulation
  always_comb begin
    emit                = 1'b0;
    push_entry.bytes    = '0;
    push_entry.last_idx = IDX_ONE;
    push_entry.status   = ST_DATA;
    hex_cnt_next        = 2'd0;
    code_next           = 16'd0;
    if (end_hit) begin
      emit              = 1'b1;
      push_entry.status = ST_UNTERM;
    end else begin
      unique case (mode)
        MODE_PLAIN: begin
          if (char_byte == CH_QUOTE) begin
            emit              = 1'b1;
            push_entry.status = ST_DONE;
          end else if (char_byte != CH_BSLASH) begin
            emit                = 1'b1;
            push_entry.bytes[0] = char_byte;
          end
        end
        MODE_ESCAPE: begin
          emit = 1'b1;
          unique case (char_byte)
            CH_U:      emit = 1'b0;
            CH_B:      push_entry.bytes[0] = VAL_BS;
            CH_F:      push_entry.bytes[0] = VAL_FF;
            CH_N:      push_entry.bytes[0] = VAL_LF;
            CH_R:      push_entry.bytes[0] = VAL_CR;
            CH_T:      push_entry.bytes[0] = VAL_HT;
            CH_BSLASH: push_entry.bytes[0] = CH_BSLASH;
            CH_SLASH:  push_entry.bytes[0] = CH_SLASH;
            CH_QUOTE:  push_entry.bytes[0] = CH_QUOTE;
            default:   push_entry.status   = ST_BADESC;
          endcase
        end
        MODE_UNICODE: begin
          if (!hex_ok) begin
            emit              = 1'b1;
            push_entry.status = ST_BADESC;
          end else if (hex_cnt != 2'd3) begin
            hex_cnt_next = hex_cnt + 2'd1;
            code_next    = cp;
          end else begin
            emit = 1'b1;
            if (cp <= UTF8_MAX1) begin
              push_entry.bytes[0] = cp[7:0];
            end else if (cp <= UTF8_MAX2) begin
              push_entry.bytes[0] = UTF8_LEAD2 | {3'd0, cp[10:6]};
              push_entry.bytes[1] = UTF8_CONT | {2'd0, cp[5:0]};
              push_entry.last_idx = IDX_TWO;
            end else begin
              push_entry.bytes[0] = UTF8_LEAD3 | {4'd0, cp[15:12]};
              push_entry.bytes[1] = UTF8_CONT | {2'd0, cp[11:6]};
              push_entry.bytes[2] = UTF8_CONT | {2'd0, cp[5:0]};
              push_entry.last_idx = IDX_THREE;
            end
          end
        end
        default: emit = 1'b0;
      endcase
    end
  end

  assign push = accept & emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_PLAIN;
      hex_cnt <= 2'd0;
      code    <= 16'd0;
    end else if (accept) begin
      mode    <= mode_next;
      hex_cnt <= hex_cnt_next;
      code    <= code_next;
    end
  end

endmodule

### rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// small command queue between front and back
// ----------------------------------------------------------------------------
module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  jsu_entry_t   push_entry,
  input  logic         pop,
  output jsu_entry_t   head,
  output jsu_q_flags_t q_flags
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  jsu_entry_t    slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign q_flags.empty = (count == '0);
  assign q_flags.full  = (count == FULL_CNT);
  assign do_push       = push & ~q_flags.full;
  assign do_pop        = pop & ~q_flags.empty;
  assign head          = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// drains queued commands one result byte per cycle, while result_stall is low, into the output register
// ----------------------------------------------------------------------------
module jsu_back
  import jsu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  jsu_entry_t   head,
  input  jsu_q_flags_t q_flags,
  output logic         pop,
  output logic         result_valid,
  input  logic         result_stall,
  output logic [7:0]   out_byte,
  output logic [1:0]   status,
  output logic         last
);

  logic [1:0] sel;
  logic       load, take, is_last;
  logic [7:0] sel_byte;

  assign load    = ~result_valid | ~result_stall;
  assign take    = load & ~q_flags.empty;
  assign is_last = (sel == head.last_idx);
  assign pop     = take & is_last;

  always_comb begin
    unique case (sel)
      IDX_TWO:   sel_byte = head.bytes[1];
      IDX_THREE: sel_byte = head.bytes[2];
      default:   sel_byte = head.bytes[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sel          <= IDX_ONE;
    end else if (load) begin
      result_valid <= ~q_flags.empty;
      if (take) begin
        sel <= is_last ? IDX_ONE : sel + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte <= sel_byte;
      status   <= head.status;
      last     <= is_last;
    end
  end

endmodule

### rtl/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// streams a json string body in, decoded utf-8 bytes and end status out
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ----------------------------
//  byte     in         byte_valid / byte_stall   char_byte, end_of_input
//  result   out        result_valid/result_stall out_byte, status, last
//
//  one byte is taken per cycle while the command queue has room; every result
//  leaves the output register at one per cycle while result_stall is low, so a
//  \u escape that makes three utf-8 bytes holds the back while the front keeps
//  going until the queue (QUEUE_DEPTH commands) fills.
//  a result passes through a queue slot and the output register after its byte is taken.
//  reset is synchronous and clears escape state and queue.
//  result_stall holds the output register and, once the queue is full,
//  raises byte_stall.
//
module json_string_unescape_utf8
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // byte channel
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] char_byte,
  input  logic       end_of_input,
  // result channel
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic [1:0] status,
  output logic       last
);

  // front to queue
  logic         push;
  jsu_entry_t   push_entry;
  // queue to back
  logic         pop;
  jsu_entry_t   head;
  jsu_q_flags_t q_flags;

  // front: escape tracking, hex gathering, utf-8 encoding
  jsu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .char_byte    (char_byte),
    .end_of_input (end_of_input),
    .q_flags      (q_flags),
    .push         (push),
    .push_entry   (push_entry)
  );

  // queue of commands, each one to three results
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_flags    (q_flags)
  );

  // back: one result transfer per cycle from the head command, while result_stall is low
  jsu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_flags      (q_flags),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .status       (status),
    .last         (last)
  );

  // terminal results are always the only and final result of their byte
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_DATA) |-> last)
    else $error("terminal result without last");

  // terminal results carry a zero byte
  a_term_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_DATA) |-> (out_byte == 8'd0))
    else $error("terminal result with nonzero byte");

  // front never writes a command into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_flags.full |-> !push)
    else $error("push into full queue");

  // back only retires a command that is present
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_flags.empty)
    else $error("pop from empty queue");

endmodule

### dv/json_string_unescape_checker.sv
// ----------------------------------------------------------------------------
// json_string_unescape_checker
// watches both channels, decodes each accepted byte on its own and compares
// the utf-8 bytes and end status that come out, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_string_unescape_checker
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic       byte_stall,
  input  logic [7:0] char_byte,
  input  logic       end_of_input,
  input  logic       result_valid,
  input  logic       result_stall,
  input  logic [7:0] out_byte,
  input  logic [1:0] status,
  input  logic       last,
  output int         fail_count,
  output int         outstanding
);

  typedef struct packed {
    logic [7:0]  data;
    jsu_status_t st;
    logic        lst;
  } decoded_t;

  decoded_t   pending_bytes[$];

  // decoder state
  logic        esc_seen;
  logic        in_unicode;
  logic [1:0]  hex_cnt;
  logic [15:0] cp_acc;

  task automatic push_byte(input logic [7:0] b, input jsu_status_t st, input logic l);
    decoded_t d;
    d.data = b;
    d.st   = st;
    d.lst  = l;
    pending_bytes.push_back(d);
  endtask

  task automatic clear_decoder();
    esc_seen   = 1'b0;
    in_unicode = 1'b0;
    hex_cnt    = 2'd0;
    cp_acc     = 16'd0;
  endtask

  task automatic end_string(input jsu_status_t st);
    clear_decoder();
    push_byte(8'h00, st, 1'b1);
  endtask

  task automatic unescape_byte(input logic [7:0] c, input logic eoi);
    logic [3:0]  nib;
    logic        nib_ok;
    logic [15:0] cp;
    logic [7:0]  v;
    logic        v_ok;
    nib_ok = 1'b1;
    nib    = 4'd0;
    v_ok   = 1'b1;
    v      = 8'h00;
    if (eoi || c == 8'h00) begin
      end_string(ST_UNTERM);
    end else if (in_unicode) begin
      if (c >= CH_0 && c <= CH_9) begin
        nib = 4'(c - CH_0);
      end else if (c >= CH_UA && c <= CH_UF) begin
        nib = 4'(c - HEX_UPPER_OFS);
      end else if (c >= CH_LA && c <= CH_LF) begin
        nib = 4'(c - HEX_LOWER_OFS);
      end else begin
        nib_ok = 1'b0;
      end
      if (!nib_ok) begin
        end_string(ST_BADESC);
      end else begin
        cp = {cp_acc[11:0], nib};
        if (hex_cnt < 2'd3) begin
          cp_acc  = cp;
          hex_cnt = hex_cnt + 2'd1;
        end else begin
          clear_decoder();
          if (cp <= UTF8_MAX1) begin
            push_byte(cp[7:0], ST_DATA, 1'b1);
          end else if (cp <= UTF8_MAX2) begin
            push_byte(UTF8_LEAD2 | {3'b000, cp[10:6]}, ST_DATA, 1'b0);
            push_byte(UTF8_CONT | {2'b00, cp[5:0]}, ST_DATA, 1'b1);
          end else begin
            push_byte(UTF8_LEAD3 | {4'h0, cp[15:12]}, ST_DATA, 1'b0);
            push_byte(UTF8_CONT | {2'b00, cp[11:6]}, ST_DATA, 1'b0);
            push_byte(UTF8_CONT | {2'b00, cp[5:0]}, ST_DATA, 1'b1);
          end
        end
      end
    end else if (esc_seen) begin
      case (c)
        CH_U: begin
          clear_decoder();
          in_unicode = 1'b1;
          v_ok       = 1'b0;
        end
        CH_B:      v = VAL_BS;
        CH_F:      v = VAL_FF;
        CH_N:      v = VAL_LF;
        CH_R:      v = VAL_CR;
        CH_T:      v = VAL_HT;
        CH_BSLASH: v = CH_BSLASH;
        CH_SLASH:  v = CH_SLASH;
        CH_QUOTE:  v = CH_QUOTE;
        default: begin
          v_ok = 1'b0;
          end_string(ST_BADESC);
        end
      endcase
      if (v_ok) begin
        esc_seen = 1'b0;
        push_byte(v, ST_DATA, 1'b1);
      end
    end else if (c == CH_QUOTE) begin
      end_string(ST_DONE);
    end else if (c == CH_BSLASH) begin
      esc_seen = 1'b1;
    end else begin
      push_byte(c, ST_DATA, 1'b1);
    end
  endtask

  initial begin
    fail_count  = 0;
    outstanding = 0;
    clear_decoder();
  end

  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      clear_decoder();
      pending_bytes.delete();
    end else begin
      if (byte_valid && !byte_stall) begin
        unescape_byte(char_byte, end_of_input);
      end
      if (result_valid && !result_stall) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected result byte %02h status %0d last %0b",
                   $time, out_byte, status, last);
          fail_count++;
        end else begin
          want = pending_bytes.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, want.data, out_byte);
            fail_count++;
          end
          if (status !== want.st) begin
            $display("%0t: status expected %s actual %0d",
                     $time, want.st.name(), status);
            fail_count++;
          end
          if (last !== want.lst) begin
            $display("%0t: last expected %0b actual %0b", $time, want.lst, last);
            fail_count++;
          end
        end
      end
    end
    outstanding = pending_bytes.size();
  end

endmodule

### dv/tb_json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8
// drives json string bodies into the unescaper: a directed set of escapes,
// code point boundaries and error endings, then random strings that are
// mostly well formed, with random idling on both sides and one long output
// hold-off; the checker beside the block decides every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8;
  import jsu_pkg::*;

  logic       clk;
  logic       rst;
  logic       byte_valid;
  logic       byte_stall;
  logic [7:0] char_byte;
  logic       end_of_input;
  logic       result_valid;
  logic       result_stall;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  int fail_count;
  int outstanding;

  // idling percentages of sender and receiver, changed per phase
  int tx_idle_pct = 34;
  int rx_idle_pct = 34;

  // long receiver hold-off, requested by the stimulus, counted by the receiver
  bit hold_req = 1'b0;
  int hold_left = 0;

  int items_sent = 0;

  // the eight single-character escape letters
  logic [7:0] esc_letters[8] = '{CH_B, CH_F, CH_N, CH_R, CH_T, CH_BSLASH, CH_SLASH,
                                  CH_QUOTE};

  json_string_unescape_utf8 u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .char_byte    (char_byte),
    .end_of_input (end_of_input),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .status       (status),
    .last         (last)
  );

  json_string_unescape_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .char_byte    (char_byte),
    .end_of_input (end_of_input),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .status       (status),
    .last         (last),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: random stall, or a long hold-off when one is requested
  initial begin
    result_stall = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 80;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // safety net against a hung handshake or results that never come
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
           (c >= CH_LA && c <= CH_LF);
  endfunction

  function automatic bit is_esc_letter(input logic [7:0] c);
    bit hit;
    hit = (c == CH_U);
    foreach (esc_letters[i]) begin
      if (c == esc_letters[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // hex digit of either case
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CH_0 + 8'(d);
    end
    if ($urandom_range(1)) begin
      return CH_UA + 8'(d) - 8'd10;
    end
    return CH_LA + 8'(d) - 8'd10;
  endfunction

  // one transfer on the byte channel, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] c, input logic e);
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid   <= 1'b1;
    char_byte    <= c;
    end_of_input <= e;
    @(posedge clk);
    while (byte_stall) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic send_unicode(input logic [15:0] cp);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_U, 1'b0);
    send_byte(hex_char(cp[15:12]), 1'b0);
    send_byte(hex_char(cp[11:8]), 1'b0);
    send_byte(hex_char(cp[7:4]), 1'b0);
    send_byte(hex_char(cp[3:0]), 1'b0);
  endtask

  // stop offering and let every expected result arrive
  task automatic drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
  endtask

  // code point biased toward each utf-8 length and its boundaries
  function automatic logic [15:0] pick_code_point();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'h007F));
      1: return 16'($urandom_range(16'h07FF, 16'h0080));
      2: return 16'($urandom);
      default: begin
        case ($urandom_range(5))
          0: return 16'h007F;
          1: return 16'h0080;
          2: return 16'h07FF;
          3: return 16'h0800;
          4: return 16'hD800;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // one string body: random segments, then mostly a closing quote and
  // otherwise a broken ending or noise
  task automatic send_random_string();
    int         segs;
    int         n_good;
    logic [7:0] c;
    logic [15:0] cp;
    segs = $urandom_range(8, 1);
    repeat (segs) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          do begin
            c = 8'($urandom_range(255, 1));
          end while (c == CH_QUOTE || c == CH_BSLASH);
          send_byte(c, 1'b0);
        end
        4, 5: begin
          send_byte(CH_BSLASH, 1'b0);
          send_byte(esc_letters[$urandom_range(7)], 1'b0);
        end
        default: send_unicode(pick_code_point());
      endcase
    end
    case ($urandom_range(19))
      13: begin
        // escape letter that is not known
        do begin
          c = 8'($urandom_range(255, 1));
        end while (is_esc_letter(c));
        send_byte(CH_BSLASH, 1'b0);
        send_byte(c, 1'b0);
      end
      14: begin
        // bad hex digit after up to three good ones
        n_good = $urandom_range(3);
        cp = pick_code_point();
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_U, 1'b0);
        for (int i = 0; i < n_good; i++) begin
          send_byte(hex_char(cp[4*i +: 4]), 1'b0);
        end
        do begin
          c = 8'($urandom_range(255, 1));
        end while (is_hex(c));
        send_byte(c, 1'b0);
      end
      15: begin
        // zero byte, sometimes right after a backslash
        if ($urandom_range(1)) begin
          send_byte(CH_BSLASH, 1'b0);
        end
        send_byte(8'h00, 1'b0);
      end
      16: send_byte(8'($urandom), 1'b1);
      17: begin
        send_byte(CH_BSLASH, 1'b0);
        send_byte(8'($urandom), 1'b1);
      end
      18, 19: send_byte(8'($urandom), ($urandom_range(15) == 0));
      default: send_byte(CH_QUOTE, 1'b0);
    endcase
  endtask

  initial begin
    bit held;
    bit paused;
    rst          = 1'b1;
    byte_valid   = 1'b0;
    char_byte    = 8'h00;
    end_of_input = 1'b0;
    held         = 1'b0;
    paused       = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: top byte value, escaped zero, code point boundaries
    send_byte(8'hFF, 1'b0);
    send_unicode(16'h0000);
    send_unicode(16'h07FF);
    send_unicode(16'hFFFF);
    // unknown escape letter
    send_byte(CH_BSLASH, 1'b0);
    send_byte(8'h78, 1'b0);
    // bad hex digit right after \u
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_U, 1'b0);
    send_byte(8'h47, 1'b0);
    // zero byte, end of input with a nonzero char, closing quote
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(CH_QUOTE, 1'b0);
    drain();

    // random strings
    items_sent = 0;
    while (items_sent < 200) begin
      if (!held && items_sent >= 50) begin
        // long output hold-off while bytes keep coming
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && items_sent >= 110) begin
        // pause the sender until everything is out
        paused = 1'b1;
        drain();
      end
      if (items_sent >= 130 && items_sent < 175) begin
        // stretch with no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = 34;
        rx_idle_pct = 34;
      end
      send_random_string();
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
dv/json_string_unescape_checker.sv
dv/tb_json_string_unescape_utf8.sv
